// File: hdl/nrcw_pkg.sv
// ----------------------------------------------------------------------------
// nrcw_pkg
// Shared types, codes and reset values for the NewReno congestion window.
// ----------------------------------------------------------------------------
package nrcw_pkg;

  localparam int OP_W      = 2;
  localparam int ACKED_W   = 24;
  localparam int TICK_W    = 32;
  localparam int WIN_W     = 32;
  localparam int MTU_W     = 16;
  localparam int PHASE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam int DIVIDEND_W = ACKED_W + MTU_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
  localparam logic [OP_W-1:0] OP_LOSS    = 2'd1;
  localparam logic [OP_W-1:0] OP_ECN     = 2'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

  localparam logic [PHASE_W-1:0] PH_SLOW  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_AVOID = 2'd1;
  localparam logic [PHASE_W-1:0] PH_RECOV = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MTU       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THR  = 2'd3;

  localparam logic [MTU_W-1:0] RST_MTU       = 16'd1252;
  localparam logic [WIN_W-1:0] RST_MIN_WIN   = 32'd2504;
  localparam logic [WIN_W-1:0] RST_INIT_WIN  = 32'd12520;
  localparam logic [WIN_W-1:0] RST_INIT_THR  = 32'hFFFF_FFFF;
  localparam logic [WIN_W-1:0] WIN_MAX       = 32'hFFFF_FFFF;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [PHASE_W-1:0] phase_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [WIN_W-1:0]      remainder;
  } nrcw_div_res_t;

endpackage

// File: hdl/nrcw_in_if.sv
// ----------------------------------------------------------------------------
// nrcw_in_if
// Event channel: one congestion event per transaction.
// ----------------------------------------------------------------------------
interface nrcw_in_if import nrcw_pkg::*; ();
  logic                valid;
  logic                ready;
  op_t                 operation;
  logic [ACKED_W-1:0]  acked_bytes;
  logic [TICK_W-1:0]   sent_time;
  logic [TICK_W-1:0]   now_time;

  modport source (output valid, operation, acked_bytes, sent_time, now_time, input ready);
  modport sink   (input valid, operation, acked_bytes, sent_time, now_time, output ready);
endinterface

// File: hdl/nrcw_out_if.sv
// ----------------------------------------------------------------------------
// nrcw_out_if
// Result channel: window, threshold and phase after each event.
// ----------------------------------------------------------------------------
interface nrcw_out_if import nrcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window;
  logic [WIN_W-1:0] threshold;
  phase_t           phase;

  modport source (output valid, window, threshold, phase, input ready);
  modport sink   (input valid, window, threshold, phase, output ready);
endinterface

// File: hdl/nrcw_cfg_if.sv
// ----------------------------------------------------------------------------
// nrcw_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface nrcw_cfg_if import nrcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/newreno_congestion_window.sv
// ----------------------------------------------------------------------------
// newreno_congestion_window
// NewReno congestion window controller: one result transaction per event.
// ----------------------------------------------------------------------------
// An event's result is loaded into the output register in the done state,
// once that register is free or being read. An ack in congestion avoidance
// with a nonzero window first grows the window: the acked_bytes * mtu_bytes
// product is registered at acceptance, the divider start state adds the
// stored remainder and starts the divider, the bit-serial divider yields the
// growth quotient and the new remainder, and the grown window is written
// back when it is done. Only one event is in flight; the event port is ready
// again once its result sits in the output register. Configuration writes
// are always taken; writes to initial_window and initial_threshold have no
// effect, and reset loads their fixed reset values.
module newreno_congestion_window import nrcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  nrcw_in_if.sink    in_ch,
  nrcw_out_if.source out_ch,
  nrcw_cfg_if.sink   cfg_ch
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIVST = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [MTU_W-1:0]       mtu_r;
  logic [WIN_W-1:0]       min_win_r;
  phase_t                 phase_r, phase_nxt;
  logic [WIN_W-1:0]       win_r, win_nxt;
  logic [WIN_W-1:0]       thr_r, thr_nxt;
  logic [TICK_W-1:0]      rec_start_r, rec_start_nxt;
  logic [WIN_W-1:0]       grow_rem_r, grow_rem_nxt;
  logic [ACKED_W+MTU_W-1:0] prod_r, prod_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]       out_win_r;
  logic [WIN_W-1:0]       out_thr_r;
  phase_t                 out_phase_r;

  logic                   in_fire;
  logic                   div_start;
  logic [DIVIDEND_W-1:0]  div_dividend;
  nrcw_div_res_t          div_res;
  logic [WIN_W:0]         ss_sum;
  logic [WIN_W-1:0]       ss_win;
  logic [WIN_W-1:0]       half_win;
  logic [TICK_W-1:0]      tick_diff;
  logic                   sent_after;
  logic [DIVIDEND_W:0]    av_sum;
  logic                   load_out;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign ss_sum     = {1'b0, win_r} + {{(WIN_W+1-ACKED_W){1'b0}}, in_ch.acked_bytes};
  assign ss_win     = ss_sum[WIN_W] ? WIN_MAX : ss_sum[WIN_W-1:0];
  assign half_win   = win_r >> 1;
  assign tick_diff  = in_ch.sent_time - rec_start_r;
  assign sent_after = (tick_diff != '0) && !tick_diff[TICK_W-1];

  assign div_start    = (state_r == S_DIVST);
  assign div_dividend = {1'b0, prod_r} + {{(DIVIDEND_W-WIN_W){1'b0}}, grow_rem_r};
  assign av_sum       = {{(DIVIDEND_W+1-WIN_W){1'b0}}, win_r}
                      + {1'b0, div_res.quotient};
  assign load_out     = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  nrcw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (win_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    win_nxt       = win_r;
    thr_nxt       = thr_r;
    rec_start_nxt = rec_start_r;
    grow_rem_nxt  = grow_rem_r;
    prod_nxt      = prod_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_DONE;
          prod_nxt  = in_ch.acked_bytes * mtu_r;
          if (in_ch.operation == OP_RESTART) begin
            win_nxt       = min_win_r;
            phase_nxt     = PH_SLOW;
            rec_start_nxt = '0;
          end else if (in_ch.operation == OP_ECN) begin
            state_nxt = S_DONE;
          end else if (phase_r == PH_AVOID) begin
            if (in_ch.operation == OP_ACK) begin
              if (win_r != '0) begin
                state_nxt = S_DIVST;
              end
            end else begin
              rec_start_nxt = in_ch.now_time;
              thr_nxt       = (half_win > min_win_r) ? half_win : min_win_r;
              phase_nxt     = PH_RECOV;
            end
          end else if (phase_r == PH_RECOV) begin
            if (in_ch.operation == OP_ACK && sent_after) begin
              phase_nxt     = PH_AVOID;
              rec_start_nxt = '0;
              win_nxt       = thr_r;
            end
          end else begin
            if (in_ch.operation == OP_ACK) begin
              win_nxt = ss_win;
              if (ss_win > thr_r) begin
                phase_nxt = PH_AVOID;
              end
            end else begin
              rec_start_nxt = in_ch.now_time;
              thr_nxt       = (half_win > min_win_r) ? half_win : min_win_r;
              phase_nxt     = PH_RECOV;
            end
          end
        end
      end
      S_DIVST: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          grow_rem_nxt = div_res.remainder;
          win_nxt      = (av_sum[DIVIDEND_W:WIN_W] != '0) ? WIN_MAX : av_sum[WIN_W-1:0];
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mtu_r       <= RST_MTU;
      min_win_r   <= RST_MIN_WIN;
      phase_r     <= PH_SLOW;
      win_r       <= RST_INIT_WIN;
      thr_r       <= RST_INIT_THR;
      rec_start_r <= '0;
      grow_rem_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      win_r       <= win_nxt;
      thr_r       <= thr_nxt;
      rec_start_r <= rec_start_nxt;
      grow_rem_r  <= grow_rem_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MTU:      mtu_r     <= cfg_ch.data[MTU_W-1:0];
          CFG_MIN_WIN:  min_win_r <= cfg_ch.data[WIN_W-1:0];
          CFG_INIT_WIN, CFG_INIT_THR: begin
          end
          default: begin
          end
        endcase
      end
    end
    prod_r <= prod_nxt;
    if (load_out) begin
      out_win_r   <= win_r;
      out_thr_r   <= thr_r;
      out_phase_r <= phase_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.window    = out_win_r;
  assign out_ch.threshold = out_thr_r;
  assign out_ch.phase     = out_phase_r;

endmodule

// File: hdl/nrcw_div.sv
// ----------------------------------------------------------------------------
// nrcw_div
// Restoring divider, one quotient bit per cycle, for avoidance growth.
// ----------------------------------------------------------------------------
module nrcw_div import nrcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [WIN_W-1:0]      divisor,
  output nrcw_div_res_t         res
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [WIN_W-1:0]      rem_r, rem_nxt;
  logic [WIN_W-1:0]      dsr_r, dsr_nxt;
  logic [WIN_W:0]        trial;
  logic [WIN_W:0]        diff;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[WIN_W]) begin
        rem_nxt = diff[WIN_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WIN_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

// File: tb/newreno_congestion_window_test.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// newreno_congestion_window_test
// Self-checking bench for the NewReno congestion window controller. A driver
// offers congestion events from a queue and a monitor takes the result
// transactions. Each accepted event runs through a local window/threshold/
// phase predictor, and every result is compared field by field with the
// oldest prediction. A directed opening covers the edge cases. Randomized
// ack/loss/ECN/restart traffic then follows under several register settings,
// with random stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module newreno_congestion_window_test;
  import nrcw_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_RESULT = 800;
  localparam int STEADY_FIRST   = 320;
  localparam int STEADY_LAST    = 480;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_EVENTS   = 225;
  localparam int PRINT_LIMIT    = 100;

  typedef struct {
    op_t                operation;
    logic [ACKED_W-1:0] acked_bytes;
    logic [TICK_W-1:0]  sent_time;
    logic [TICK_W-1:0]  now_time;
  } cc_event_t;

  typedef struct {
    logic [WIN_W-1:0] window;
    logic [WIN_W-1:0] threshold;
    phase_t           phase;
  } window_report_t;

  logic clk;
  logic rst_n;

  nrcw_in_if  in_bus ();
  nrcw_out_if out_bus ();
  nrcw_cfg_if cfg_bus ();

  newreno_congestion_window dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  cc_event_t      pending_events[$];
  window_report_t expected_windows[$];
  cc_event_t      offered_event;

  logic [MTU_W-1:0]  reg_mtu;
  logic [WIN_W-1:0]  reg_min_window;
  logic [WIN_W-1:0]  reg_init_window;
  logic [WIN_W-1:0]  reg_init_threshold;

  phase_t            cw_phase;
  logic [WIN_W-1:0]  cw_window;
  logic [WIN_W-1:0]  cw_threshold;
  logic [TICK_W-1:0] cw_recovery_tick;
  logic [WIN_W-1:0]  cw_growth_rem;

  logic [TICK_W-1:0] event_tick;
  int mismatches   = 0;
  int sent_count   = 0;
  int result_count = 0;
  int queued_count = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [WIN_W-1:0] saturating_grow(input logic [WIN_W-1:0] base,
                                                       input logic [63:0] step);
    logic [63:0] sum;
    sum = 64'(base) + step;
    return (sum > 64'(WIN_MAX)) ? WIN_MAX : sum[WIN_W-1:0];
  endfunction

  function automatic void enter_recovery(input logic [TICK_W-1:0] now);
    logic [WIN_W-1:0] half;
    half             = cw_window >> 1;
    cw_recovery_tick = now;
    cw_threshold     = (half > reg_min_window) ? half : reg_min_window;
    cw_phase         = PH_RECOV;
  endfunction

  function automatic void predict_window(input cc_event_t ev);
    logic [63:0]       total;
    logic [63:0]       quot;
    logic [TICK_W-1:0] gap;
    window_report_t    rep;
    if (ev.operation == OP_RESTART) begin
      cw_window        = reg_min_window;
      cw_phase         = PH_SLOW;
      cw_recovery_tick = '0;
    end else if (ev.operation != OP_ECN) begin
      case (cw_phase)
        PH_AVOID: begin
          if (ev.operation == OP_ACK) begin
            if (cw_window != '0) begin
              total         = 64'(ev.acked_bytes) * 64'(reg_mtu) + 64'(cw_growth_rem);
              quot          = total / 64'(cw_window);
              cw_growth_rem = 32'(total % 64'(cw_window));
              cw_window     = saturating_grow(cw_window, quot);
            end
          end else begin
            enter_recovery(ev.now_time);
          end
        end
        PH_RECOV: begin
          if (ev.operation == OP_ACK) begin
            gap = ev.sent_time - cw_recovery_tick;
            if (gap != '0 && !gap[TICK_W-1]) begin
              cw_phase         = PH_AVOID;
              cw_recovery_tick = '0;
              cw_window        = cw_threshold;
            end
          end
        end
        default: begin
          if (ev.operation == OP_ACK) begin
            cw_window = saturating_grow(cw_window, 64'(ev.acked_bytes));
            if (cw_window > cw_threshold) cw_phase = PH_AVOID;
          end else begin
            enter_recovery(ev.now_time);
          end
        end
      endcase
    end
    rep.window    = cw_window;
    rep.threshold = cw_threshold;
    rep.phase     = cw_phase;
    expected_windows.push_back(rep);
  endfunction

  function automatic cc_event_t random_event();
    cc_event_t ev;
    int        pick;
    event_tick    += $urandom_range(0, 40);
    ev.now_time    = event_tick;
    ev.sent_time   = event_tick - $urandom_range(0, 120);
    pick = $urandom_range(0, 99);
    if (pick < 64)      ev.operation = OP_ACK;
    else if (pick < 80) ev.operation = OP_LOSS;
    else if (pick < 90) ev.operation = OP_ECN;
    else                ev.operation = OP_RESTART;
    case ($urandom_range(0, 9))
      7:       ev.acked_bytes = ACKED_W'($urandom);
      8:       ev.acked_bytes = '0;
      9:       ev.acked_bytes = '1;
      default: ev.acked_bytes = ACKED_W'($urandom_range(0, 3 * int'(reg_mtu)));
    endcase
    if ($urandom_range(0, 99) < 8) begin
      ev.operation   = OP_W'($urandom);
      ev.acked_bytes = ACKED_W'($urandom);
      ev.sent_time   = $urandom;
      ev.now_time    = $urandom;
    end
    return ev;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: %s mismatch, got 0x%08h, expected 0x%08h", $time, what, got, want);
  endtask

  task automatic queue_event(input op_t op, input logic [ACKED_W-1:0] acked,
                             input logic [TICK_W-1:0] sent, input logic [TICK_W-1:0] now);
    cc_event_t ev;
    ev.operation   = op;
    ev.acked_bytes = acked;
    ev.sent_time   = sent;
    ev.now_time    = now;
    pending_events.push_back(ev);
    queued_count++;
  endtask

  task automatic drain_events();
    do @(posedge clk);
    while (pending_events.size() != 0 || result_count < queued_count);
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      pending_events.push_back(random_event());
      queued_count++;
    end
    drain_events();
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_MTU:      reg_mtu            = value[MTU_W-1:0];
      CFG_MIN_WIN:  reg_min_window     = value;
      CFG_INIT_WIN: reg_init_window    = value;
      CFG_INIT_THR: reg_init_threshold = value;
      default: ;
    endcase
  endtask

  // event driver
  always @(posedge clk) begin : event_driver
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_window(offered_event);
        sent_count++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_events.size() != 0 &&
            ((sent_count >= STEADY_FIRST && sent_count < STEADY_LAST) ||
             $urandom_range(0, 99) >= 27)) begin
          offered_event         = pending_events.pop_front();
          in_bus.valid         <= 1'b1;
          in_bus.operation     <= offered_event.operation;
          in_bus.acked_bytes   <= offered_event.acked_bytes;
          in_bus.sent_time     <= offered_event.sent_time;
          in_bus.now_time      <= offered_event.now_time;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    window_report_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        result_count++;
        if (expected_windows.size() == 0) begin
          flag_mismatch("unexpected result window", out_bus.window, '0);
        end else begin
          want = expected_windows.pop_front();
          if (out_bus.window !== want.window)
            flag_mismatch("window", out_bus.window, want.window);
          if (out_bus.threshold !== want.threshold)
            flag_mismatch("threshold", out_bus.threshold, want.threshold);
          if (out_bus.phase !== want.phase)
            flag_mismatch("phase", 32'(out_bus.phase), 32'(want.phase));
        end
        if (result_count == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= (result_count >= STEADY_FIRST && result_count < STEADY_LAST) ||
                         ($urandom_range(0, 99) >= 27);
      end
    end
  end

  // watchdog: stop when no transaction moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("newreno_congestion_window test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    in_bus.valid       = 1'b0;
    in_bus.operation   = OP_ACK;
    in_bus.acked_bytes = '0;
    in_bus.sent_time   = '0;
    in_bus.now_time    = '0;
    out_bus.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_MTU;
    cfg_bus.data       = '0;

    reg_mtu            = RST_MTU;
    reg_min_window     = RST_MIN_WIN;
    reg_init_window    = RST_INIT_WIN;
    reg_init_threshold = RST_INIT_THR;
    cw_phase           = PH_SLOW;
    cw_window          = reg_init_window;
    cw_threshold       = reg_init_threshold;
    cw_recovery_tick   = '0;
    cw_growth_rem      = '0;
    event_tick         = $urandom;

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // slow start, recovery entry at tick zero, exit tests around the wrap
    queue_event(OP_ECN,     '0,         '0,             '0);
    queue_event(OP_ACK,     '0,         '0,             '0);
    queue_event(OP_ACK,     '1,         '0,             '0);
    queue_event(OP_LOSS,    '0,         '0,             '0);
    queue_event(OP_LOSS,    24'd5,      '0,             32'd5);
    queue_event(OP_ECN,     24'd7,      32'd3,          32'd3);
    queue_event(OP_ACK,     24'd1000,   '0,             '0);
    queue_event(OP_ACK,     24'd1000,   32'h8000_0000,  '0);
    queue_event(OP_ACK,     24'd1000,   32'd1,          32'd1);
    queue_event(OP_ACK,     '1,         32'd5,          32'd5);
    queue_event(OP_ACK,     '0,         32'd6,          32'd6);
    queue_event(OP_ECN,     '0,         '0,             '0);
    queue_event(OP_LOSS,    '0,         '0,             32'h7FFF_FFFF);
    queue_event(OP_ACK,     24'd100,    32'hFFFF_FFFF,  '0);
    queue_event(OP_ACK,     24'd100,    32'hFFFF_FFFE,  '0);
    queue_event(OP_RESTART, '0,         '0,             '0);
    queue_event(OP_LOSS,    '0,         '0,             '1);
    queue_event(OP_ACK,     24'd100,    '0,             '0);
    queue_event(OP_RESTART, '1,         '1,             '1);
    drain_events();

    // saturation at the top of the window range
    write_register(CFG_MTU, CFG_DAT_W'(16'hFFFF));
    write_register(CFG_MIN_WIN, '1);
    write_register(CFG_INIT_WIN, $urandom);
    write_register(CFG_INIT_THR, '0);
    queue_event(OP_RESTART, '0,         '0,             '0);
    queue_event(OP_ACK,     '1,         32'd1,          32'd1);
    queue_event(OP_ACK,     '1,         32'd2,          32'd2);
    queue_event(OP_LOSS,    '0,         32'd10,         32'd10);
    queue_event(OP_ACK,     '1,         32'd11,         32'd12);
    queue_event(OP_ACK,     '1,         32'd12,         32'd13);
    drain_events();

    write_register(CFG_MIN_WIN, 32'd1);
    write_register(CFG_INIT_WIN, 32'd1);
    write_register(CFG_INIT_THR, '1);
    run_random(PHASE_EVENTS);

    write_register(CFG_MTU, 32'd1);
    write_register(CFG_MIN_WIN, RST_MIN_WIN);
    event_tick = 32'hFFFF_FC00;
    run_random(PHASE_EVENTS);

    repeat (3) begin
      write_register(CFG_MTU, $urandom_range(1, 65535));
      write_register(CFG_MIN_WIN, ($urandom_range(0, 3) == 0) ? ($urandom | 32'd1)
                                                               : $urandom_range(1, 200000));
      run_random(PHASE_EVENTS);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("newreno_congestion_window test passed");
    end else begin
      $display("newreno_congestion_window test failed");
    end
    $finish;
  end

endmodule
